// ----- src/pair_linear_restraint_force_unit_macros.svh -----
// Assertion macros shared by the checker of the pair linear restraint force unit.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef PAIR_LINEAR_RESTRAINT_FORCE_UNIT_MACROS_SVH
`define PAIR_LINEAR_RESTRAINT_FORCE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PLRF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plrf check failed");

// next-cycle implication, disabled in reset
`define PLRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plrf check failed");

`endif

// ----- src/plrf_pkg.sv -----
// Shared constants of the pair linear restraint force unit.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package plrf_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int VALUE_W  = 32;   // energy, force and alpha width
  localparam int TARGET_W = 31;   // target distance width
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FORCE_CONSTANT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DISTANCE = 8'd1;

  localparam logic [VALUE_W-1:0]  ALPHA_RESET  = 32'h0001_0000;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 31'h0001_0000;

endpackage

// ----- src/plrf_if.sv -----
// Channel interfaces of the pair linear restraint force unit: input, result, config.
// Depends on plrf_pkg for field widths.
`timescale 1ns / 1ps

interface plrf_in_if #(
  parameter int COORD_WIDTH = plrf_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] ref_x;
  logic signed [COORD_WIDTH-1:0] ref_y;
  logic signed [COORD_WIDTH-1:0] ref_z;

  modport source (output valid, first_x, first_y, first_z, ref_x, ref_y, ref_z,
                  input ready);
  modport sink   (input valid, first_x, first_y, first_z, ref_x, ref_y, ref_z,
                  output ready);
endinterface

interface plrf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plrf_pkg::VALUE_W-1:0] energy;
  logic signed [plrf_pkg::VALUE_W-1:0] force_x;
  logic signed [plrf_pkg::VALUE_W-1:0] force_y;
  logic signed [plrf_pkg::VALUE_W-1:0] force_z;
  logic                                saturated;

  modport source (output valid, energy, force_x, force_y, force_z, saturated,
                  input ready);
  modport sink   (input valid, energy, force_x, force_y, force_z, saturated,
                  output ready);
endinterface

interface plrf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [plrf_pkg::CFG_IDX_W-1:0]  index;
  logic [plrf_pkg::VALUE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/plrf_mul.sv -----
// Two-stage unsigned multiplier: two partial products, then their sum.
// No dependencies; advances only when en is high.
`timescale 1ns / 1ps

module plrf_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int BL = BW / 2;
  localparam int BH = BW - BL;

  logic [AW+BL-1:0] pl_r;
  logic [AW+BH-1:0] ph_r;
  logic [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= (AW+BL)'(a) * (AW+BL)'(b[BL-1:0]);
      ph_r <= (AW+BH)'(a) * (AW+BH)'(b[BW-1:BL]);
      p_r  <= (AW+BW)'(pl_r) + ((AW+BW)'(ph_r) << BL);
    end
  end

  assign p = p_r;

endmodule

// ----- src/plrf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// No dependencies; an entry stage, then the quotient stages; advances only when en is high.
`timescale 1ns / 1ps

module plrf_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int HW = NW - QW;
  localparam int MW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_r [0:QW];
  logic [QW-1:0] lo_r  [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic          ovf_r [0:QW];

  logic [MW-1:0] hi_e;
  logic [MW-1:0] den_e;

  assign hi_e  = MW'(num[NW-1:QW]);
  assign den_e = MW'(den);

  // entry stage: a high part at or above the divisor means the quotient does not fit
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_e[DW-1:0];
      lo_r[0]  <= num[QW-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      ovf_r[0] <= (hi_e >= den_e);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;
    logic [DW:0] trial;
    assign trial = {rem_r[k], lo_r[k][BIT]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= (DW+1)'(den_r[k])) begin
          rem_r[k+1] <= DW'(trial - (DW+1)'(den_r[k]));
          q_r[k+1]   <= q_r[k] | (QW'(1) << BIT);
        end else begin
          rem_r[k+1] <= trial[DW-1:0];
          q_r[k+1]   <= q_r[k];
        end
        lo_r[k+1]  <= lo_r[k];
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// ----- src/pair_linear_restraint_force_unit.sv -----
// Top level of the pair linear restraint force unit.
// Depends on plrf_pkg, plrf_if, plrf_mul and plrf_div.
`timescale 1ns / 1ps
//
// Usage:
//   in_ch  : one pair per transfer, restrained point (first_*) and reference
//            point (ref_*), signed fixed point with FRAC_BITS fraction bits.
//   out_ch : one result per pair, in order: energy, force on the restrained
//            point, and a saturated flag when any field was clipped.
//   cfg_ch : register writes, index 0 force_constant, 1 target_distance;
//            other indexes are dropped. Always ready. Write only while idle.
// Throughput: one pair per cycle, sustained while no result waits on out_ch.ready.
// Depth: set by the square root, one root bit per stage, and the
//   dividers, which run side by side, one quotient bit per stage.
// Reset: rst_n low clears all valid bits and loads the registers with 1.0.
// Stall: the whole pipeline holds while a result waits and out_ch.ready is
//   low; in_ch.ready then drops in the same cycle, so nothing is lost.

module pair_linear_restraint_force_unit #(
  parameter int FRAC_BITS   = plrf_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = plrf_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  plrf_in_if.sink    in_ch,
  plrf_out_if.source out_ch,
  plrf_cfg_if.sink   cfg_ch
);

  localparam int CW  = COORD_WIDTH;
  localparam int VW  = plrf_pkg::VALUE_W;
  localparam int TW  = plrf_pkg::TARGET_W;
  localparam int RW  = CW + 1;          // root width
  localparam int SW  = 2 * CW + 2;      // sum of squares width
  localparam int NE  = VW + RW;         // energy numerator
  localparam int NF  = VW + CW + FRAC_BITS; // force numerator
  localparam int DF  = TW + RW;         // force divisor
  localparam int LA  = RW + 3;          // T1 to root out
  localparam int LB  = VW + 3;          // root out to divider out
  localparam int LAT = RW + VW + 8;

  // configuration
  logic [VW-1:0] alpha_r;
  logic [TW-1:0] target_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= plrf_pkg::ALPHA_RESET;
      target_r <= plrf_pkg::TARGET_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        plrf_pkg::REG_FORCE_CONSTANT:  alpha_r  <= cfg_ch.data;
        plrf_pkg::REG_TARGET_DISTANCE: target_r <= cfg_ch.data[TW-1:0];
        default: ;
      endcase
    end
  end

  logic          aneg;
  logic [VW-1:0] amag;
  logic [TW-1:0] tgt;

  assign aneg = alpha_r[VW-1];
  assign amag = aneg ? (~alpha_r + VW'(1)) : alpha_r;
  // a zero target counts as one LSB
  assign tgt  = (target_r == '0) ? TW'(1) : target_r;

  // pipeline advance: hold everything while a result waits
  logic           en;
  logic           in_fire;
  logic [LAT:1]   vld_r;

  assign en          = !vld_r[LAT] || out_ch.ready;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_fire};
    end
  end

  // stage 1: differences and magnitudes, carried along until the root is out
  logic [2:0][CW-1:0] dm_r   [0:LA];
  logic [2:0]         dneg_r [0:LA];
  logic [2:0][CW:0]   diff;

  assign diff[0] = {in_ch.first_x[CW-1], in_ch.first_x} - {in_ch.ref_x[CW-1], in_ch.ref_x};
  assign diff[1] = {in_ch.first_y[CW-1], in_ch.first_y} - {in_ch.ref_y[CW-1], in_ch.ref_y};
  assign diff[2] = {in_ch.first_z[CW-1], in_ch.first_z} - {in_ch.ref_z[CW-1], in_ch.ref_z};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dneg_r[0][i] <= diff[i][CW];
        dm_r[0][i]   <= diff[i][CW] ? CW'(~diff[i] + (CW+1)'(1)) : diff[i][CW-1:0];
      end
      for (int k = 1; k <= LA; k++) begin
        dm_r[k]   <= dm_r[k-1];
        dneg_r[k] <= dneg_r[k-1];
      end
    end
  end

  // squares, then their sum
  logic [2*CW-1:0] sq_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    plrf_mul #(.AW(CW), .BW(CW)) u_sq (
      .clk (clk), .en (en), .a (dm_r[0][i]), .b (dm_r[0][i]), .p (sq_w[i])
    );
  end

  // square root, one bit per stage; remainder tracks sum - root^2
  logic [SW-1:0] rem_r  [0:RW];
  logic [RW-1:0] root_r [0:RW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= SW'(sq_w[0]) + SW'(sq_w[1]) + SW'(sq_w[2]);
      root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int B = RW - 1 - j;
    logic [SW-1:0] trial;
    assign trial = (SW'(root_r[j]) << (B + 1)) + (SW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[j] >= trial) begin
          rem_r[j+1]  <= rem_r[j] - trial;
          root_r[j+1] <= root_r[j] | (RW'(1) << B);
        end else begin
          rem_r[j+1]  <= rem_r[j];
          root_r[j+1] <= root_r[j];
        end
      end
    end
  end

  // root is out: flags for the force, products for both quotients
  logic [RW-1:0]      root;
  logic [RW+TW-1:0]   root_e;
  logic [RW+TW-1:0]   tgt_e;
  logic               zf;
  logic               flip;
  logic               zf_r   [1:LB];
  logic               flip_r [1:LB];
  logic [2:0]         sneg_r [1:LB];

  assign root   = root_r[RW];
  assign root_e = (RW+TW)'(root);
  assign tgt_e  = (RW+TW)'(tgt);
  // force is zero at zero distance or exactly at the target
  assign zf     = (root == '0) || (root_e == tgt_e);
  assign flip   = root_e > tgt_e;

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[1]   <= zf;
      flip_r[1] <= flip;
      sneg_r[1] <= dneg_r[LA];
      for (int k = 2; k <= LB; k++) begin
        zf_r[k]   <= zf_r[k-1];
        flip_r[k] <= flip_r[k-1];
        sneg_r[k] <= sneg_r[k-1];
      end
    end
  end

  logic [NE-1:0] enum_w;
  logic [DF-1:0] fden_w;
  logic [VW-1:0] equo_w;
  logic          eovf_w;

  plrf_mul #(.AW(VW), .BW(RW)) u_emul (
    .clk (clk), .en (en), .a (amag), .b (root), .p (enum_w)
  );

  plrf_mul #(.AW(TW), .BW(RW)) u_dmul (
    .clk (clk), .en (en), .a (tgt), .b (root), .p (fden_w)
  );

  plrf_div #(.NW(NE), .DW(TW), .QW(VW)) u_ediv (
    .clk (clk), .en (en), .num (enum_w), .den (tgt), .quo (equo_w), .ovf (eovf_w)
  );

  logic [VW+CW-1:0] fnum_w [3];
  logic [VW-1:0]    fquo_w [3];
  logic             fovf_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_force
    plrf_mul #(.AW(VW), .BW(CW)) u_fmul (
      .clk (clk), .en (en), .a (amag), .b (dm_r[LA][i]), .p (fnum_w[i])
    );
    plrf_div #(.NW(NF), .DW(DF), .QW(VW)) u_fdiv (
      .clk (clk), .en (en), .num ({fnum_w[i], {FRAC_BITS{1'b0}}}), .den (fden_w),
      .quo (fquo_w[i]), .ovf (fovf_w[i])
    );
  end

  // apply sign after the magnitude and clip to 32-bit signed; bit VW flags a clip
  function automatic logic [VW:0] pack_value(input logic [VW-1:0] q, input logic ovf,
                                             input logic neg);
    logic [VW-1:0] lim;
    logic [VW-1:0] m;
    logic          clip;
    lim  = neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    clip = ovf || (q > lim);
    m    = clip ? lim : q;
    return {clip, neg ? (~m + VW'(1)) : m};
  endfunction

  logic [VW:0]   epk;
  logic [VW:0]   fpk [3];
  logic [VW-1:0] energy_r;
  logic [VW-1:0] force_r [3];
  logic          sat_r;

  assign epk = pack_value(equo_w, eovf_w, aneg);

  for (genvar i = 0; i < 3; i++) begin : g_pack
    logic fneg;
    // a zero quotient never carries a sign
    assign fneg = (aneg ^ sneg_r[LB][i] ^ flip_r[LB]) && (fovf_w[i] || fquo_w[i] != '0);
    assign fpk[i] = zf_r[LB] ? '0 : pack_value(fquo_w[i], fovf_w[i], fneg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      energy_r <= epk[VW-1:0];
      for (int i = 0; i < 3; i++) begin
        force_r[i] <= fpk[i][VW-1:0];
      end
      sat_r <= epk[VW] || fpk[0][VW] || fpk[1][VW] || fpk[2][VW];
    end
  end

  assign out_ch.valid     = vld_r[LAT];
  assign out_ch.energy    = energy_r;
  assign out_ch.force_x   = force_r[0];
  assign out_ch.force_y   = force_r[1];
  assign out_ch.force_z   = force_r[2];
  assign out_ch.saturated = sat_r;

endmodule

// ----- src/plrf_checker.sv -----
// Port-level checks of the pair linear restraint force unit, bound to the top level.
// Depends on plrf_pkg and pair_linear_restraint_force_unit_macros.svh.
`timescale 1ns / 1ps
`include "pair_linear_restraint_force_unit_macros.svh"

module plrf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [plrf_pkg::VALUE_W-1:0] out_energy,
  input logic [plrf_pkg::VALUE_W-1:0] out_force_x,
  input logic                      out_saturated,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  logic [2*plrf_pkg::VALUE_W:0] out_held;

  assign out_held = {out_energy, out_force_x, out_saturated};

  // a stalled result holds
  `PLRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_held))

  // input takes a transfer whenever the output register is free or drains
  `PLRF_ASSERT_IMPL(a_in_ready, !out_valid || out_ready, in_ready)

  // a held result blocks new input
  `PLRF_ASSERT_IMPL(a_in_block, out_valid && !out_ready, !in_ready)

  // configuration never stalls
  `PLRF_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind pair_linear_restraint_force_unit plrf_checker u_plrf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_energy    (out_ch.energy),
  .out_force_x   (out_ch.force_x),
  .out_saturated (out_ch.saturated),
  .cfg_valid     (cfg_ch.valid),
  .cfg_ready     (cfg_ch.ready)
);

// ----- tb/pair_linear_restraint_force_unit_check.sv -----
// Checker for the pair linear restraint force unit: tracks register writes,
// predicts each result from accepted pairs and compares transfers on out_ch.
// Depends on plrf_pkg and the channel interfaces in plrf_if.
`timescale 1ns / 1ps

module pair_linear_restraint_force_unit_check (
  input  logic clk,
  input  logic rst_n,
  plrf_in_if   in_ch,
  plrf_out_if  out_ch,
  plrf_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  localparam int FRAC = plrf_pkg::FRAC_BITS_DEF;

  typedef struct {
    logic [31:0] energy;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic        saturated;
  } restraint_result_t;

  logic [plrf_pkg::VALUE_W-1:0]  alpha_q;
  logic [plrf_pkg::TARGET_W-1:0] target_q;
  restraint_result_t             result_q[$];

  function automatic logic [31:0] clip32(logic [127:0] mag, bit neg, inout bit clipped);
    logic [127:0] limit;
    logic [127:0] m;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    m = mag;
    if (mag > limit) begin
      m = limit;
      clipped = 1'b1;
    end
    return neg ? (32'd0 - m[31:0]) : m[31:0];
  endfunction

  function automatic restraint_result_t predict_force(
      logic signed [31:0] pa [3], logic signed [31:0] pb [3],
      logic [31:0] alpha, logic [30:0] target);
    restraint_result_t res;
    longint       d [3];
    logic [127:0] dm [3];
    logic [127:0] sum, r, c, amag, tgt, den, num;
    bit           aneg, clipped, flip, neg;
    sum = '0;
    clipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = longint'(pa[i]) - longint'(pb[i]);
      dm[i] = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
      sum   = sum + dm[i] * dm[i];
    end
    r = '0;
    for (int b = 49; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= sum) r = c;
    end
    aneg = alpha[31];
    amag = aneg ? (128'h1_0000_0000 - 128'(alpha)) : 128'(alpha);
    tgt  = (target == 0) ? 128'd1 : 128'(target);
    res.energy = clip32((amag * r) / tgt, aneg, clipped);
    if (r == 0 || r == tgt) begin
      res.force_x = '0;
      res.force_y = '0;
      res.force_z = '0;
    end else begin
      flip = r > tgt;
      den  = tgt * r;
      for (int i = 0; i < 3; i++) begin
        neg = aneg ^ (d[i] < 0) ^ flip;
        num = ((amag * dm[i]) << FRAC) / den;
        if (num == 0) neg = 1'b0;
        case (i)
          0: res.force_x = clip32(num, neg, clipped);
          1: res.force_y = clip32(num, neg, clipped);
          default: res.force_z = clip32(num, neg, clipped);
        endcase
      end
    end
    res.saturated = clipped;
    return res;
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] pa [3];
    logic signed [31:0] pb [3];
    restraint_result_t  exp_r;
    int                 errs;
    errs = 0;
    if (!rst_n) begin
      alpha_q    <= plrf_pkg::ALPHA_RESET;
      target_q   <= plrf_pkg::TARGET_RESET;
      fail_count <= 0;
      pending    <= 0;
      result_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == plrf_pkg::REG_FORCE_CONSTANT) begin
          alpha_q <= cfg_ch.data;
        end else if (cfg_ch.index == plrf_pkg::REG_TARGET_DISTANCE) begin
          target_q <= cfg_ch.data[plrf_pkg::TARGET_W-1:0];
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pa = '{in_ch.first_x, in_ch.first_y, in_ch.first_z};
        pb = '{in_ch.ref_x, in_ch.ref_y, in_ch.ref_z};
        result_q.push_back(predict_force(pa, pb, alpha_q, target_q));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no pair outstanding");
          errs++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_ch.energy !== exp_r.energy) begin
            $error("energy: expected %h, got %h", exp_r.energy, out_ch.energy);
            errs++;
          end
          if (out_ch.force_x !== exp_r.force_x) begin
            $error("force_x: expected %h, got %h", exp_r.force_x, out_ch.force_x);
            errs++;
          end
          if (out_ch.force_y !== exp_r.force_y) begin
            $error("force_y: expected %h, got %h", exp_r.force_y, out_ch.force_y);
            errs++;
          end
          if (out_ch.force_z !== exp_r.force_z) begin
            $error("force_z: expected %h, got %h", exp_r.force_z, out_ch.force_z);
            errs++;
          end
          if (out_ch.saturated !== exp_r.saturated) begin
            $error("saturated: expected %b, got %b", exp_r.saturated, out_ch.saturated);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= result_q.size();
    end
  end
endmodule

// ----- tb/pair_linear_restraint_force_unit_test.sv -----
// Stimulus and verdict for the pair linear restraint force unit.
// Depends on plrf_pkg, plrf_if, the block and pair_linear_restraint_force_unit_check.
`timescale 1ns / 1ps

module pair_linear_restraint_force_unit_test;

  localparam int LATENCY = plrf_pkg::COORD_WIDTH_DEF + 41;
  localparam int PHASE_ITEMS = 260;
  localparam int HOLD_CYCLES = 300;
  // an index past the two registers; the block must drop the write
  localparam logic [plrf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   hold_left = 0;   // cycles the receiver still holds off
  bit   quiet = 1'b0;    // suppress random idling on both sides
  int   sent = 0;

  plrf_in_if #(.COORD_WIDTH(plrf_pkg::COORD_WIDTH_DEF)) in_ch ();
  plrf_out_if out_ch ();
  plrf_cfg_if cfg_ch ();

  pair_linear_restraint_force_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pair_linear_restraint_force_unit_check check (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  // Give up long after the slowest correct run could have finished.
  initial begin
    #5ms;
    $display("pair_linear_restraint_force_unit_test failed");
    $finish;
  end

  // Receiver: drop ready at random, or for a whole hold-off stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = quiet || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // Offer one pair; hold it until the transfer happens.
  task automatic send_pair(logic [31:0] fx, fy, fz, rx, ry, rz);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.first_x = fx; in_ch.first_y = fy; in_ch.first_z = fz;
    in_ch.ref_x = rx;   in_ch.ref_y = ry;   in_ch.ref_z = rz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Drain the pipeline completely before touching a register.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [plrf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Random pair, mostly in the physically useful ranges, with some full-range noise.
  task automatic send_random(logic [30:0] target);
    logic [31:0] p [6];
    int sel;
    for (int i = 0; i < 6; i++) p[i] = $urandom;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      case (sel)
        0, 1, 2: begin   // nearby points, small separation
          p[i+3] = $signed(p[i+3]) >>> 10;
          p[i]   = p[i+3] + ($signed($urandom) >>> 13);
        end
        3: begin         // separation around the target scale
          p[i+3] = $signed(p[i+3]) >>> 4;
          p[i]   = p[i+3] + ($signed($urandom) >>> ($urandom_range(0, 3) + 12));
        end
        4: ;             // full range
        5: begin         // exactly the target distance along one axis
          p[i+3] = $signed(p[i+3]) >>> 2;
          p[i]   = p[i+3];
          if (i == 0) p[i] = $urandom_range(0, 1) ? p[i+3] + target : p[i+3] - target;
        end
        6: p[i] = p[i+3];  // coincident points
        7: begin           // target plus or minus a few lsb
          p[i+3] = $signed(p[i+3]) >>> 2;
          p[i]   = p[i+3];
          if (i == 0) p[i] = p[i+3] + target + $urandom_range(0, 4) - 2;
        end
        default: begin     // one axis large, others small
          if (i != 0) p[i] = p[i+3] + ($signed($urandom) >>> 20);
        end
      endcase
    end
    send_pair(p[0], p[1], p[2], p[3], p[4], p[5]);
  endtask

  logic [31:0] alpha_set [6];
  logic [31:0] target_set [6];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.first_x = '0; in_ch.first_y = '0; in_ch.first_z = '0;
    in_ch.ref_x = '0;   in_ch.ref_y = '0;   in_ch.ref_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pairs at the reset settings (alpha 1.0, target 1.0).
    send_pair(0, 0, 0, 0, 0, 0);                                   // zero distance
    send_pair(32'h0001_0000, 0, 0, 0, 0, 0);                       // exactly target
    send_pair(0, 32'hFFFF_0000, 0, 0, 0, 0);                       // target, negative axis
    send_pair(32'h0000_8000, 0, 0, 0, 0, 0);                       // inside target
    send_pair(0, 0, 32'h0003_0000, 0, 0, 0);                       // outside target
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);        // largest separation
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(1, 0, 0, 0, 0, 0);                                   // one lsb
    send_pair(32'h0001_0001, 32'h0000_0001, 0, 0, 0, 0);           // just past target
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    send_pair(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0);           // coincident at minimum
    send_pair(32'h0000_FFFF, 0, 0, 0, 0, 0);                       // just inside target
    wait_idle();
    write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);                        // must be dropped
    send_pair(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 0, 0, 0);

    // Hold the receiver off long enough to fill the pipeline and stall the input.
    hold_left = HOLD_CYCLES;
    for (int n = 0; n < PHASE_ITEMS; n++) send_random(plrf_pkg::TARGET_RESET);

    alpha_set  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                   32'hFFFF_0000, $urandom, $urandom};
    target_set = '{32'h0000_0001, 32'h7FFF_FFFF, $urandom_range(1, 32'h00FF_FFFF),
                   32'h0000_0000, $urandom_range(1, 32'h0004_0000), $urandom};
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(plrf_pkg::REG_FORCE_CONSTANT, alpha_set[ph]);
      write_reg(plrf_pkg::REG_TARGET_DISTANCE, target_set[ph]);
      quiet = (ph == 2);   // one phase runs flat out on both sides
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_pair(target_set[ph][30:0], 0, 0, 0, 0, 0);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(target_set[ph][30:0]);
      quiet = 1'b0;
    end

    // Drain and let the last result settle.
    wait_idle();
    $display("Covered %0d pairs over seven register settings, including alpha and",
             sent);
    $display("target extremes, zero target, coincident points and on-target pairs.");
    if (fail_count == 0) begin
      $display("pair_linear_restraint_force_unit_test passed");
    end else begin
      $display("pair_linear_restraint_force_unit_test failed");
    end
    $finish;
  end
endmodule
